>>> rtl/core/twrrs_pkg.sv
// Package for the time-window round-robin selector.
// Holds shared widths, bound table layout, state encoding and time helpers.
// No dependencies.
package twrrs_pkg;

    localparam int SLOTS_DEF = 16;
    localparam int UNITS     = 6;
    localparam int BOUND_W   = 6;
    localparam int HALF_W    = UNITS * BOUND_W;
    localparam int ENTRY_W   = 2 * HALF_W;
    localparam int COUNT_W   = 5;
    localparam int SLOT_W    = 4;
    localparam int UNIT_W    = 3;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Entry layout: low bounds in the lower half, high bounds in the upper half,
    // unit u at bits [u*6 +: 6] of each half.
    localparam logic [ENTRY_W-1:0] ENTRY_RST = {{HALF_W{1'b1}}, {HALF_W{1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_WR_MOD,
        S_SCAN,
        S_FINISH
    } t_state;

    typedef logic [UNITS-1:0][BOUND_W-1:0] t_time;

    // Sunday-zero weekday to Monday-zero, (wd + 6) mod 7 over all 3-bit codes.
    function automatic logic [BOUND_W-1:0] weekday_mon0(input logic [2:0] wd);
        logic [2:0] r;
        begin
            if (wd == 3'd0 || wd == 3'd7) begin
                r = 3'd6;
            end else begin
                r = wd - 3'd1;
            end
            weekday_mon0 = {3'b000, r};
        end
    endfunction

endpackage

>>> rtl/core/time_window_round_robin_selector_unit.sv
// Time-window round-robin selector, top level.
// Uses twrrs_pkg and one twrrs_ram holding the per-slot bound table.
//
// Usage:
//   Input stream (s_axis_*): tuser is op (0 write bounds, 1 query). A write sets
//   the low/high bound of one calendar unit of one slot. A query carries the
//   current time; it scans slot_count slots, at most SLOTS, cyclically from the
//   round-robin pointer and returns the first slot whose windows all hold
//   that time, then moves the pointer just past it. A miss returns found = 0.
//   Output stream (m_axis_*): one item per input item, in order; tdata holds
//   chosen_slot, tuser holds found.
//   Config channel (cfg_*): writes slot_count; always ready; write only idle.
// Flow: one item in flight at a time. A write goes through table read, merge
//   and write back, then result; one dropped for a bad slot or unit goes
//   straight to the result. A query does a first table read, then compares
//   slots, each compare overlapping the next read, then the result; it compares
//   at most min(slot_count, SLOTS) slots, none when slot_count is 0.
// Reset: slot_count = 1, pointer 0, every slot unconstrained (valid bits
//   cleared, no sweep). A stalled output holds its item; the next input item
//   is taken while it waits, and its result waits in turn.
module time_window_round_robin_selector_unit
    import twrrs_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write: slot_count
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,   // [4:0] slot_count
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [3:0] slot_index, [6:4] unit_index, [12:7] bound_low, [18:13] bound_high,
    // [22:19] month, [27:23] day_of_month, [30:28] weekday, [35:31] hour,
    // [41:36] minute, [47:42] second
    input  logic [47:0] s_axis_tdata,
    input  logic        s_axis_tuser,  // [0] op
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // [3:0] chosen_slot
    output logic        m_axis_tuser   // [0] found
);

    localparam int IDXW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_LIM = (SLOTS < 31) ? SLOTS : 31;

    t_state               r_state, n_state;
    logic [COUNT_W-1:0]   r_slot_count;
    logic [COUNT_W-1:0]   r_ptr, n_ptr;
    logic [SLOTS-1:0]     r_valid;
    logic                 r_rd_vld, n_rd_vld;
    logic [COUNT_W-1:0]   r_idx, n_idx;
    logic [COUNT_W-1:0]   r_left, n_left;
    logic [SLOT_W-1:0]    r_wslot, n_wslot;
    logic [UNIT_W-1:0]    r_unit, n_unit;
    logic [BOUND_W-1:0]   r_blo, n_blo;
    logic [BOUND_W-1:0]   r_bhi, n_bhi;
    t_time                r_time, n_time;
    logic [SLOT_W-1:0]    r_res_slot, n_res_slot;
    logic                 r_res_found, n_res_found;
    logic                 r_out_valid, n_out_valid;
    logic [SLOT_W-1:0]    r_out_slot, n_out_slot;
    logic                 r_out_found, n_out_found;

    logic                 ram_we, ram_re;
    logic [IDXW-1:0]      ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0]   ram_wdata, ram_q, entry;
    logic                 set_valid;

    logic [COUNT_W-1:0]   count, start, next_idx;
    logic                 hit, wr_ok;
    logic [SLOT_W-1:0]    in_slot;
    logic [UNIT_W-1:0]    in_unit;

    assign count = (r_slot_count > COUNT_W'(CNT_LIM)) ? COUNT_W'(CNT_LIM) : r_slot_count;
    assign start = (r_ptr < count) ? r_ptr : '0;
    assign next_idx = (r_idx + COUNT_W'(1) == count) ? '0 : r_idx + COUNT_W'(1);

    assign in_slot = s_axis_tdata[3:0];
    assign in_unit = s_axis_tdata[6:4];
    assign wr_ok   = (32'(in_slot) < SLOTS) && (in_unit < UNIT_W'(UNITS));

    // Slots never written read as unconstrained.
    assign entry = r_rd_vld ? ram_q : ENTRY_RST;

    always_comb begin
        hit = 1'b1;
        for (int u = 0; u < UNITS; u++) begin
            if (r_time[u] < entry[u*BOUND_W +: BOUND_W] ||
                r_time[u] > entry[HALF_W + u*BOUND_W +: BOUND_W]) begin
                hit = 1'b0;
            end
        end
    end

    always_comb begin
        ram_wdata = entry;
        for (int u = 0; u < UNITS; u++) begin
            if (r_unit == UNIT_W'(u)) begin
                ram_wdata[u*BOUND_W +: BOUND_W]          = r_blo;
                ram_wdata[HALF_W + u*BOUND_W +: BOUND_W] = r_bhi;
            end
        end
    end

    twrrs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS),
        .AW    (IDXW)
    ) u_bounds (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_rd_vld    = r_rd_vld;
        n_idx       = r_idx;
        n_left      = r_left;
        n_wslot     = r_wslot;
        n_unit      = r_unit;
        n_blo       = r_blo;
        n_bhi       = r_bhi;
        n_time      = r_time;
        n_res_slot  = r_res_slot;
        n_res_found = r_res_found;
        n_out_valid = r_out_valid;
        n_out_slot  = r_out_slot;
        n_out_found = r_out_found;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_waddr   = IDXW'(r_wslot);
        ram_raddr   = IDXW'(in_slot);
        set_valid   = 1'b0;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_wslot     = in_slot;
                    n_unit      = in_unit;
                    n_blo       = s_axis_tdata[12:7];
                    n_bhi       = s_axis_tdata[18:13];
                    n_time[0]   = BOUND_W'(s_axis_tdata[22:19]) + BOUND_W'(1);
                    n_time[1]   = BOUND_W'(s_axis_tdata[27:23]);
                    n_time[2]   = weekday_mon0(s_axis_tdata[30:28]);
                    n_time[3]   = BOUND_W'(s_axis_tdata[35:31]);
                    n_time[4]   = s_axis_tdata[41:36];
                    n_time[5]   = s_axis_tdata[47:42];
                    n_res_slot  = in_slot;
                    n_res_found = 1'b0;
                    if (s_axis_tuser == OP_WRITE) begin
                        if (wr_ok) begin
                            ram_re    = 1'b1;
                            ram_raddr = IDXW'(in_slot);
                            n_rd_vld  = r_valid[IDXW'(in_slot)];
                            n_state   = S_WR_MOD;
                        end else begin
                            n_state = S_FINISH;
                        end
                    end else begin
                        n_res_slot = '0;
                        if (count == '0) begin
                            n_state = S_FINISH;
                        end else begin
                            ram_re    = 1'b1;
                            ram_raddr = IDXW'(start);
                            n_rd_vld  = r_valid[IDXW'(start)];
                            n_idx     = start;
                            n_left    = count;
                            n_state   = S_SCAN;
                        end
                    end
                end
            end
            S_WR_MOD: begin
                ram_we    = 1'b1;
                ram_waddr = IDXW'(r_wslot);
                set_valid = 1'b1;
                n_state   = S_FINISH;
            end
            S_SCAN: begin
                if (hit) begin
                    n_ptr       = next_idx;
                    n_res_slot  = r_idx[SLOT_W-1:0];
                    n_res_found = 1'b1;
                    n_state     = S_FINISH;
                end else if (r_left == COUNT_W'(1)) begin
                    n_state = S_FINISH;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = IDXW'(next_idx);
                    n_rd_vld  = r_valid[IDXW'(next_idx)];
                    n_idx     = next_idx;
                    n_left    = r_left - COUNT_W'(1);
                end
            end
            S_FINISH: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_slot  = r_res_slot;
                    n_out_found = r_res_found;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_slot_count <= COUNT_W'(1);
            r_ptr        <= '0;
            r_valid      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_slot_count <= i_cfg_data[COUNT_W-1:0];
            end
            if (set_valid) begin
                r_valid[IDXW'(r_wslot)] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_vld    <= n_rd_vld;
        r_idx       <= n_idx;
        r_left      <= n_left;
        r_wslot     <= n_wslot;
        r_unit      <= n_unit;
        r_blo       <= n_blo;
        r_bhi       <= n_bhi;
        r_time      <= n_time;
        r_res_slot  <= n_res_slot;
        r_res_found <= n_res_found;
        r_out_slot  <= n_out_slot;
        r_out_found <= n_out_found;
    end

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_slot};
    assign m_axis_tuser  = r_out_found;

endmodule

>>> rtl/core/twrrs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the slot bound table. No dependencies.
module twrrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> tb/slot_selection_checker.sv
// Scoreboard for the time-window round-robin selector: watches the config,
// input and result channels, predicts each result and compares it.
// Depends on twrrs_pkg.
module slot_selection_checker
    import twrrs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [47:0] i_in_data,   // same layout as s_axis_tdata
    input  logic        i_in_op,     // [0] op
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_out_data,  // [3:0] chosen_slot
    input  logic        i_out_found, // [0] found
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = SLOTS_DEF;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              found;
    } t_selection;

    logic [BOUND_W-1:0] win_lo [NSLOT][UNITS];
    logic [BOUND_W-1:0] win_hi [NSLOT][UNITS];
    int                 slot_cnt = 1;
    int                 rr_ptr   = 0;
    int                 fails    = 0;
    t_selection         selection_q[$];

    function automatic void note_mismatch(input string field, input int want, input int got);
        fails++;
        $error("%s: expected %0d, actual %0d", field, want, got);
    endfunction

    // Applies one item to the window table and the pointer, returns its result.
    function automatic t_selection select_slot(input logic op, input logic [47:0] d);
        t_selection r;
        int         tm [UNITS];
        int         cnt;
        int         first;
        int         s;
        int         k;
        int         u;
        logic       hit;
        r = '0;
        if (op == OP_WRITE) begin
            if (d[6:4] < UNITS) begin
                win_lo[d[3:0]][d[6:4]] = d[12:7];
                win_hi[d[3:0]][d[6:4]] = d[18:13];
            end
            r.slot = d[3:0];
            return r;
        end
        tm[0] = int'(d[22:19]) + 1;
        tm[1] = int'(d[27:23]);
        tm[2] = (int'(d[30:28]) + 6) % 7;   // Sunday-first to Monday-first
        tm[3] = int'(d[35:31]);
        tm[4] = int'(d[41:36]);
        tm[5] = int'(d[47:42]);
        cnt   = (slot_cnt > NSLOT) ? NSLOT : slot_cnt;
        first = (rr_ptr < cnt) ? rr_ptr : 0;
        for (k = 0; k < cnt; k++) begin
            s   = (first + k) % cnt;
            hit = 1'b1;
            for (u = 0; u < UNITS; u++) begin
                if (tm[u] < int'(win_lo[s][u]) || tm[u] > int'(win_hi[s][u])) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                rr_ptr  = (s + 1) % cnt;
                r.slot  = s[SLOT_W-1:0];
                r.found = 1'b1;
                return r;
            end
        end
        return r;   // miss: pointer stays
    endfunction

    always @(posedge i_clk) begin
        t_selection want;
        if (!i_rst_n) begin
            slot_cnt = 1;
            rr_ptr   = 0;
            for (int s = 0; s < NSLOT; s++) begin
                for (int u = 0; u < UNITS; u++) begin
                    win_lo[s][u] = '0;
                    win_hi[s][u] = '1;
                end
            end
            selection_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (selection_q.size() == 0) begin
                    note_mismatch("chosen_slot (no item pending)", -1, i_out_data[SLOT_W-1:0]);
                end else begin
                    want = selection_q.pop_front();
                    if (i_out_data[SLOT_W-1:0] !== want.slot) begin
                        note_mismatch("chosen_slot", want.slot, i_out_data[SLOT_W-1:0]);
                    end
                    if (i_out_found !== want.found) begin
                        note_mismatch("found", want.found, i_out_found);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                slot_cnt = int'(i_cfg_data[COUNT_W-1:0]);
            end
            if (i_in_valid && i_in_ready) begin
                selection_q.push_back(select_slot(i_in_op, i_in_data));
            end
        end
        o_fail_count <= fails;
        o_pending    <= selection_q.size();
    end

endmodule

>>> tb/tb_time_window_round_robin_selector_unit.sv
// Testbench top for time_window_round_robin_selector_unit: clock, reset,
// directed and random item traffic, slot_count phases and the verdict.
// Depends on twrrs_pkg, the selector RTL and slot_selection_checker.
module tb_time_window_round_robin_selector_unit
    import twrrs_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 40;
    localparam int PHASE_ITEMS  = 175;
    localparam int UNIT_MAX     = (1 << UNIT_W) - 1;

    typedef enum logic [2:0] {
        U_MONTH,
        U_DAY,
        U_WEEKDAY,
        U_HOUR,
        U_MINUTE,
        U_SECOND
    } t_unit;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // slot, unit, bound_low, bound_high, month, day, weekday, hour, minute, second
    logic [47:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;   // [0] op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;           // [3:0] chosen_slot
    logic        m_axis_tuser;           // [0] found

    int          fail_count;
    int          results_pending;
    int          cycle_count = 0;
    int          cur_count   = 1;
    logic        hold_req    = 1'b0;
    logic        quiet       = 1'b0;

    always #5ns i_clk = ~i_clk;

    time_window_round_robin_selector_unit #(
        .SLOTS(SLOTS_DEF)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    slot_selection_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_in_op     (s_axis_tuser),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .i_out_found (m_axis_tuser),
        .o_fail_count(fail_count),
        .o_pending   (results_pending)
    );

    function automatic logic [47:0] pack_item(
        input logic [3:0] slot, input logic [2:0] unit,
        input logic [5:0] lo, input logic [5:0] hi,
        input logic [3:0] mon, input logic [4:0] day, input logic [2:0] wd,
        input logic [4:0] hr, input logic [5:0] mn, input logic [5:0] sc
    );
        return {sc, mn, hr, wd, day, mon, hi, lo, unit, slot};
    endfunction

    // Called at a rising edge; returns at the edge where the item was taken.
    task automatic send_item(input logic op, input logic [47:0] d);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= d;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic sender_gap(input int n);
        s_axis_tvalid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (results_pending != 0);
    endtask

    task automatic write_bounds(input logic [3:0] slot, input logic [2:0] unit,
                                input logic [5:0] lo, input logic [5:0] hi);
        send_item(OP_WRITE, pack_item(slot, unit, lo, hi, '0, '0, '0, '0, '0, '0));
    endtask

    task automatic query_time(input logic [3:0] mon, input logic [4:0] day,
                              input logic [2:0] wd, input logic [4:0] hr,
                              input logic [5:0] mn, input logic [5:0] sc);
        send_item(OP_QUERY, pack_item('0, '0, '0, '0, mon, day, wd, hr, mn, sc));
    endtask

    task automatic write_slot_count(input int cnt);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= {3'($urandom_range(0, 7)), 5'(cnt)};
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_count = cnt;
    endtask

    task automatic send_random_item();
        logic [47:0] d;
        logic [2:0]  unit;
        int          nom;
        int          mid;
        d = {16'($urandom), 32'($urandom)};
        if ($urandom_range(0, 99) < 35) begin
            if (cur_count >= 1 && cur_count <= SLOTS_DEF && $urandom_range(0, 3) != 0) begin
                d[3:0] = 4'($urandom_range(0, cur_count - 1));
            end
            if ($urandom_range(0, 9) == 0) begin
                unit = 3'($urandom_range(UNITS, UNIT_MAX));
            end else begin
                unit = 3'($urandom_range(0, UNITS - 1));
            end
            case (unit)
                U_MONTH:   nom = 12;
                U_DAY:     nom = 31;
                U_WEEKDAY: nom = 6;
                U_HOUR:    nom = 23;
                U_MINUTE:  nom = 59;
                U_SECOND:  nom = 60;
                default:   nom = 63;
            endcase
            mid = nom / 2;
            case ($urandom_range(0, 9)) inside
                [0:2]: begin
                    d[12:7]  = '0;
                    d[18:13] = '1;
                end
                [3:7]: begin
                    d[12:7]  = 6'($urandom_range(0, mid));
                    d[18:13] = 6'($urandom_range(mid, 63));
                end
                default: ;  // raw bounds, often an empty window
            endcase
            d[6:4] = unit;
            send_item(OP_WRITE, d);
        end else begin
            // mostly calendar-legal times, otherwise the raw field values
            if ($urandom_range(0, 6) != 0) begin
                d[22:19] = 4'($urandom_range(0, 11));
                d[27:23] = 5'($urandom_range(1, 31));
                d[30:28] = 3'($urandom_range(0, 6));
                d[35:31] = 5'($urandom_range(0, 23));
                d[41:36] = 6'($urandom_range(0, 59));
                d[47:42] = 6'($urandom_range(0, 60));
            end
            send_item(OP_QUERY, d);
        end
    endtask

    // result side back-pressure
    initial begin
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (quiet || $urandom_range(0, 9) < 6) begin
                m_axis_tready <= 1'b1;
                if (quiet) begin
                    @(posedge i_clk);
                end else if ($urandom_range(0, 4) == 0) begin
                    repeat ($urandom_range(40, 100)) @(posedge i_clk);
                end else begin
                    repeat ($urandom_range(1, 20)) @(posedge i_clk);
                end
            end else begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int phase_counts [10];
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset state: one slot, fully open
        query_time(4'd0, 5'd1, 3'd0, 5'd0, 6'd0, 6'd0);
        query_time(4'd15, 5'd31, 3'd7, 5'd31, 6'd63, 6'd63);
        write_bounds(4'd0, U_MONTH, 6'd63, 6'd0);      // empty window
        query_time(4'd5, 5'd10, 3'd3, 5'd12, 6'd30, 6'd30);
        write_bounds(4'd0, U_MONTH, 6'd0, 6'd63);
        write_bounds(4'd15, 3'(UNITS), 6'd5, 6'd5);    // dropped, unit out of range
        write_bounds(4'd15, 3'(UNIT_MAX), 6'd7, 6'd9);
        write_bounds(4'd1, U_WEEKDAY, 6'd0, 6'd0);     // Mondays only
        write_bounds(4'd2, U_SECOND, 6'd60, 6'd60);    // leap second only
        write_bounds(4'd3, U_HOUR, 6'd23, 6'd23);
        write_slot_count(0);
        query_time(4'd0, 5'd1, 3'd1, 5'd23, 6'd0, 6'd60);
        write_slot_count(31);                          // saturates to all slots
        repeat (4) query_time(4'd0, 5'd1, 3'd1, 5'd23, 6'd0, 6'd60);
        query_time(4'd11, 5'd31, 3'd0, 5'd0, 6'd59, 6'd0);
        write_slot_count(2);                           // pointer now past the count
        query_time(4'd11, 5'd31, 3'd0, 5'd0, 6'd59, 6'd0);
        query_time(4'd11, 5'd31, 3'd0, 5'd0, 6'd59, 6'd0);
        write_bounds(4'd0, U_DAY, 6'd31, 6'd31);
        query_time(4'd0, 5'd1, 3'd0, 5'd0, 6'd0, 6'd0);
        query_time(4'd0, 5'd31, 3'd1, 5'd0, 6'd0, 6'd0);

        phase_counts = '{16, 1, 31, 0, 5, 0, 0, 16, 8, 3};
        phase_counts[5] = $urandom_range(1, SLOTS_DEF);
        phase_counts[6] = $urandom_range(0, (1 << COUNT_W) - 1);
        for (int p = 0; p < 10; p++) begin
            write_slot_count(phase_counts[p]);
            quiet = (p == 9);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 2 && i == 40) begin
                    hold_req = 1'b1;   // sender keeps offering while results back up
                end
                if (p == 4 && i == 80) begin
                    drain();
                end
                send_random_item();
                if (!quiet && $urandom_range(0, 4) == 0) begin
                    sender_gap($urandom_range(1, 11));
                end
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/twrrs_pkg.sv
rtl/core/twrrs_ram.sv
rtl/core/time_window_round_robin_selector_unit.sv
tb/slot_selection_checker.sv
tb/tb_time_window_round_robin_selector_unit.sv
